FILE: sv/pidpv_pkg.sv
// Shared types and constants for the PID position/velocity controller.
// No dependencies; imported by pid_position_velocity.
package pidpv_pkg;

	localparam int GAIN_W     = 16;
	localparam int DRIVE_W    = 16;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;
	localparam int STEP_W     = 4;

	localparam logic signed [31:0] S32_MAX    = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] S32_MIN    = 32'sh8000_0000;
	localparam logic signed [31:0] ROUND_BIAS = 32'sd128;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_GAIN_P,
		REG_GAIN_I,
		REG_GAIN_D,
		REG_FILTER_ALPHA,
		REG_DEAD_ZONE,
		REG_INTEGRAL_LIMIT,
		REG_OUTPUT_LIMIT,
		REG_LOOP_MODE
	} cfg_reg_t;

	localparam logic [1:0] MODE_NONE = 2'd0;
	localparam logic [1:0] MODE_POS  = 2'd1;
	localparam logic [1:0] MODE_VEL  = 2'd2;

	localparam logic OP_COMPUTE = 1'b0;
	localparam logic OP_CLEAR   = 1'b1;

	localparam logic STATUS_OK      = 1'b0;
	localparam logic STATUS_NO_MODE = 1'b1;

	// saturate a wide signed value to 32 bits signed
	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		logic signed [31:0] r;
		if (v > 64'(S32_MAX)) begin
			r = S32_MAX;
		end else if (v < 64'(S32_MIN)) begin
			r = S32_MIN;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

endpackage

FILE: sv/pid_position_velocity.sv
// PID controller, positional or incremental form, fixed point with bit-serial products.
// Depends on pidpv_pkg.
// Each product runs through one shift-add unit, one gain bit per cycle; the block takes
// one item at a time and accepts the next only once the last result is in the output register.
// arst_n clears state, filter and output; config resets to zero.
module pid_position_velocity #(
	parameter int SAMPLE_BITS = 16
) (
	input  logic                                      clk,
	input  logic                                      arst_n,
	// target [SAMPLE_BITS-1:0], measure [2*SAMPLE_BITS-1:SAMPLE_BITS], zero pad
	input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0]        s_tdata,
	// operation
	input  logic                                      s_tuser,
	input  logic                                      s_tvalid,
	output logic                                      s_tready,
	// drive
	output logic [pidpv_pkg::DRIVE_W-1:0]             m_tdata,
	// status
	output logic                                      m_tuser,
	output logic                                      m_tvalid,
	input  logic                                      m_tready,
	input  logic                                      cfg_valid,
	output logic                                      cfg_ready,
	input  logic [pidpv_pkg::CFG_IDX_W-1:0]           cfg_index,
	input  logic [pidpv_pkg::CFG_DATA_W-1:0]          cfg_data
);
	import pidpv_pkg::*;

	localparam int SB    = SAMPLE_BITS;
	localparam int EW    = SB + 1;
	localparam int OW    = (SB + 3 > 32) ? SB + 3 : 32;
	localparam int ACC_W = (SB + 20 > 52) ? SB + 20 : 52;
	localparam int SUM_W = ACC_W - 8;
	localparam int CMP_W = (EW > 16) ? EW : 16;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SETUP,
		ST_MUL_D,
		ST_D_DONE,
		ST_MUL_F,
		ST_F_DONE,
		ST_MUL_P,
		ST_MUL_I,
		ST_SUM,
		ST_OUT
	} state_t;

	state_t state_q;

	// configuration
	logic signed [GAIN_W-1:0] kp_q, ki_q, kd_q;
	logic [15:0]              alpha_q, dz_q;
	logic [30:0]              ilim_q;
	logic [14:0]              olim_q;
	logic [1:0]               mode_q;

	// item and controller state
	logic                     op_q;
	logic signed [SB-1:0]     tgt_q, meas_q;
	logic signed [EW-1:0]     err_prev_q, err_prev2_q;
	logic signed [31:0]       integ_q, fv_q;
	logic signed [DRIVE_W-1:0] held_q;
	logic                     status_q;

	// serial multiply unit
	logic signed [OW-1:0]     px_q, ix_q;
	logic signed [ACC_W-1:0]  acc_q, mcand_q;
	logic [GAIN_W-1:0]        mplier_q;
	logic                     msigned_q;
	logic [STEP_W-1:0]        cnt_q;

	logic                     m_tvalid_q, m_tuser_q;
	logic [DRIVE_W-1:0]       m_tdata_q;

	// combinational helpers
	logic                     none_c, below_dz_c, last_step_c;
	logic signed [EW-1:0]     err_c;
	logic [EW-1:0]            err_abs_c;
	logic signed [31:0]       ilim_s_c, integ_sat_c, integ_new_c;
	logic signed [OW-1:0]     diff1_c, diff2_c, px_c, ix_c, dx_c;
	logic signed [ACC_W-1:0]  addend_c, acc_step_c;
	logic signed [31:0]       d_sat_c, fv_new_c;
	logic signed [32:0]       fdiff_c;
	logic signed [SUM_W-1:0]  sum_c, out_c, lim_c;
	logic signed [DRIVE_W-1:0] held_new_c;

	assign s_tready  = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;
	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = m_tdata_q;
	assign m_tuser   = m_tuser_q;

	always_comb begin
		none_c     = (mode_q != MODE_POS) && (mode_q != MODE_VEL);
		err_c      = EW'(tgt_q) - EW'(meas_q);
		// magnitude of the most negative error wraps to the right unsigned value
		err_abs_c  = err_c[EW-1] ? EW'(-err_c) : EW'(err_c);
		below_dz_c = CMP_W'(err_abs_c) < CMP_W'(dz_q);

		ilim_s_c    = $signed({1'b0, ilim_q});
		integ_sat_c = sat32(64'(integ_q) + 64'(err_c));
		if (ki_q == '0) begin
			integ_new_c = '0;
		end else if (integ_sat_c > ilim_s_c) begin
			integ_new_c = ilim_s_c;
		end else if (integ_sat_c < -ilim_s_c) begin
			integ_new_c = -ilim_s_c;
		end else begin
			integ_new_c = integ_sat_c;
		end

		diff1_c = OW'(err_c) - OW'(err_prev_q);
		diff2_c = OW'(err_c) - (OW'(err_prev_q) <<< 1) + OW'(err_prev2_q);
		if (mode_q == MODE_POS) begin
			px_c = OW'(err_c);
			ix_c = OW'(integ_new_c);
			dx_c = diff1_c;
		end else begin
			px_c = diff1_c;
			ix_c = OW'(err_c);
			dx_c = diff2_c;
		end

		// shift-add step; the top gain bit weighs negative for signed gains
		last_step_c = (cnt_q == {STEP_W{1'b1}});
		addend_c    = (msigned_q && last_step_c) ? -mcand_q : mcand_q;
		acc_step_c  = mplier_q[0] ? acc_q + addend_c : acc_q;

		d_sat_c  = sat32(64'(acc_q));
		fdiff_c  = 33'(d_sat_c) - 33'(fv_q);
		fv_new_c = sat32(64'(fv_q) + 64'(acc_q >>> 16));

		sum_c = SUM_W'(acc_q >>> 8);
		out_c = (mode_q == MODE_POS) ? sum_c : SUM_W'(held_q) + sum_c;
		lim_c = SUM_W'($signed({1'b0, olim_q}));
		if (out_c > lim_c) begin
			held_new_c = DRIVE_W'(lim_c);
		end else if (out_c < -lim_c) begin
			held_new_c = DRIVE_W'(-lim_c);
		end else begin
			held_new_c = DRIVE_W'(out_c);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kp_q    <= '0;
			ki_q    <= '0;
			kd_q    <= '0;
			alpha_q <= '0;
			dz_q    <= '0;
			ilim_q  <= '0;
			olim_q  <= '0;
			mode_q  <= MODE_NONE;
		end else if (cfg_valid) begin
			case (cfg_reg_t'(cfg_index))
				REG_GAIN_P:         kp_q    <= cfg_data[GAIN_W-1:0];
				REG_GAIN_I:         ki_q    <= cfg_data[GAIN_W-1:0];
				REG_GAIN_D:         kd_q    <= cfg_data[GAIN_W-1:0];
				REG_FILTER_ALPHA:   alpha_q <= cfg_data[15:0];
				REG_DEAD_ZONE:      dz_q    <= cfg_data[15:0];
				REG_INTEGRAL_LIMIT: ilim_q  <= cfg_data[30:0];
				REG_OUTPUT_LIMIT:   olim_q  <= cfg_data[14:0];
				REG_LOOP_MODE:      mode_q  <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			op_q        <= OP_COMPUTE;
			tgt_q       <= '0;
			meas_q      <= '0;
			err_prev_q  <= '0;
			err_prev2_q <= '0;
			integ_q     <= '0;
			fv_q        <= '0;
			held_q      <= '0;
			status_q    <= STATUS_OK;
			px_q        <= '0;
			ix_q        <= '0;
			acc_q       <= '0;
			mcand_q     <= '0;
			mplier_q    <= '0;
			msigned_q   <= 1'b0;
			cnt_q       <= '0;
			m_tvalid_q  <= 1'b0;
			m_tdata_q   <= '0;
			m_tuser_q   <= STATUS_OK;
		end else begin
			if (m_tready && state_q != ST_OUT) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						op_q    <= s_tuser;
						tgt_q   <= s_tdata[SB-1:0];
						meas_q  <= s_tdata[2*SB-1:SB];
						state_q <= ST_SETUP;
					end
				end
				ST_SETUP: begin
					if (op_q == OP_CLEAR || none_c) begin
						err_prev_q  <= '0;
						err_prev2_q <= '0;
						integ_q     <= '0;
						held_q      <= '0;
						status_q    <= none_c ? STATUS_NO_MODE : STATUS_OK;
						state_q     <= ST_OUT;
					end else begin
						err_prev2_q <= err_prev_q;
						err_prev_q  <= err_c;
						status_q    <= STATUS_OK;
						if (below_dz_c) begin
							state_q <= ST_OUT;
						end else begin
							if (mode_q == MODE_POS) begin
								integ_q <= integ_new_c;
							end
							px_q      <= px_c;
							ix_q      <= ix_c;
							acc_q     <= '0;
							mcand_q   <= ACC_W'(dx_c);
							mplier_q  <= kd_q;
							msigned_q <= 1'b1;
							cnt_q     <= '0;
							state_q   <= ST_MUL_D;
						end
					end
				end
				ST_MUL_D, ST_MUL_F, ST_MUL_P, ST_MUL_I: begin
					acc_q <= acc_step_c;
					cnt_q <= cnt_q + 1'b1;
					if (last_step_c && state_q == ST_MUL_P) begin
						// I product accumulates on top of P
						mcand_q   <= ACC_W'(ix_q);
						mplier_q  <= ki_q;
						msigned_q <= 1'b1;
						state_q   <= ST_MUL_I;
					end else begin
						mcand_q  <= mcand_q <<< 1;
						mplier_q <= mplier_q >> 1;
						if (last_step_c) begin
							case (state_q)
								ST_MUL_D: state_q <= ST_D_DONE;
								ST_MUL_F: state_q <= ST_F_DONE;
								default:  state_q <= ST_SUM;
							endcase
						end
					end
				end
				ST_D_DONE: begin
					if (alpha_q != '0) begin
						acc_q     <= '0;
						mcand_q   <= ACC_W'(fdiff_c);
						mplier_q  <= alpha_q;
						msigned_q <= 1'b0;
						state_q   <= ST_MUL_F;
					end else begin
						acc_q     <= ACC_W'(d_sat_c) + ACC_W'(ROUND_BIAS);
						mcand_q   <= ACC_W'(px_q);
						mplier_q  <= kp_q;
						msigned_q <= 1'b1;
						state_q   <= ST_MUL_P;
					end
				end
				ST_F_DONE: begin
					fv_q      <= fv_new_c;
					acc_q     <= ACC_W'(fv_new_c) + ACC_W'(ROUND_BIAS);
					mcand_q   <= ACC_W'(px_q);
					mplier_q  <= kp_q;
					msigned_q <= 1'b1;
					state_q   <= ST_MUL_P;
				end
				ST_SUM: begin
					held_q  <= held_new_c;
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q <= 1'b1;
						m_tdata_q  <= held_q;
						m_tuser_q  <= status_q;
						state_q    <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// an unconfigured result always carries a zero drive
	a_no_mode_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser == STATUS_NO_MODE) |-> (m_tdata == '0))
		else $error("unconfigured result with nonzero drive");

	// step counter runs only inside the multiply states
	a_cnt_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_MUL_D && state_q != ST_MUL_F &&
		 state_q != ST_MUL_P && state_q != ST_MUL_I) |-> (cnt_q == '0))
		else $error("step counter out of sync with multiply states");

	// a clear item wipes history and integral once the setup state has been passed
	a_clear_wipes: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && s_tuser == OP_CLEAR) |=> ##1
		(err_prev_q == '0 && err_prev2_q == '0 && integ_q == '0 && held_q == '0))
		else $error("clear item left controller state");

	// a new result only appears when leaving the output state
	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid_q) |-> $past(state_q == ST_OUT))
		else $error("result raised outside output state");

endmodule

FILE: bench/tb_top.sv
// Self-checking bench for pid_position_velocity: drives control samples and register writes,
// predicts every drive/status item with a fixed-point PID model and compares in order.
// Depends on pidpv_pkg and the pid_position_velocity RTL.
module tb_top;
	import pidpv_pkg::*;

	localparam int ITEM_TARGET    = 1500;
	localparam int HOLD_CYCLES    = 500;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int TAIL_CYCLES    = 80;

	typedef struct packed {
		logic [DRIVE_W-1:0] drive;
		logic               status;
	} drive_result_t;

	// Controller model plus the queue of drive items still to come out
	class pid_scoreboard;
		logic signed [15:0] kp, ki, kd;
		logic [15:0]        alpha, dead_band;
		logic [30:0]        integ_limit;
		logic [14:0]        out_limit;
		logic [1:0]         mode;
		longint             err_prev, err_prev2, integ, held, filt;
		drive_result_t      drive_expected[$];
		int                 errors, inputs_seen, clears_seen, results_checked;

		function new();
			kp = 0; ki = 0; kd = 0; alpha = 0; dead_band = 0;
			integ_limit = 0; out_limit = 0; mode = MODE_NONE;
			err_prev = 0; err_prev2 = 0; integ = 0; held = 0; filt = 0;
			errors = 0; inputs_seen = 0; clears_seen = 0; results_checked = 0;
		endfunction

		function void write_reg(cfg_reg_t idx, logic [31:0] val);
			case (idx)
				REG_GAIN_P:         kp = val[15:0];
				REG_GAIN_I:         ki = val[15:0];
				REG_GAIN_D:         kd = val[15:0];
				REG_FILTER_ALPHA:   alpha = val[15:0];
				REG_DEAD_ZONE:      dead_band = val[15:0];
				REG_INTEGRAL_LIMIT: integ_limit = val[30:0];
				REG_OUTPUT_LIMIT:   out_limit = val[14:0];
				REG_LOOP_MODE:      mode = val[1:0];
				default: ;
			endcase
		endfunction

		function longint clip(longint v, longint lo, longint hi);
			return (v < lo) ? lo : ((v > hi) ? hi : v);
		endfunction

		function longint sat_word(longint v);
			return clip(v, 64'shFFFF_FFFF_8000_0000, 64'sh0000_0000_7FFF_FFFF);
		endfunction

		// low-pass on the D term; filter state only moves while alpha is nonzero
		function longint smooth_deriv(longint d);
			if (alpha == 0) begin
				return d;
			end
			filt = sat_word(filt + ((longint'(alpha) * (d - filt)) >>> 16));
			return filt;
		endfunction

		function void clear_history();
			err_prev = 0;
			err_prev2 = 0;
			integ = 0;
			held = 0;
		endfunction

		function void take_sample(logic op, logic signed [15:0] tgt, logic signed [15:0] meas);
			bit            none;
			longint        e, e1, e2, sum, lim;
			drive_result_t r;
			inputs_seen++;
			none = (mode != MODE_POS) && (mode != MODE_VEL);
			lim = longint'(out_limit);
			if (op == OP_CLEAR || none) begin
				if (op == OP_CLEAR) begin
					clears_seen++;
				end
				clear_history();
				r.drive = '0;
				r.status = none ? STATUS_NO_MODE : STATUS_OK;
				drive_expected.push_back(r);
				return;
			end
			e = longint'(tgt) - longint'(meas);
			e1 = err_prev;
			e2 = err_prev2;
			err_prev2 = e1;
			err_prev = e;
			if (((e < 0) ? -e : e) >= longint'(dead_band)) begin
				if (mode == MODE_POS) begin
					integ = (ki != 0) ? sat_word(integ + e) : 0;
					integ = clip(integ, -longint'(integ_limit), longint'(integ_limit));
					sum = longint'(kp) * e + longint'(ki) * integ
						+ smooth_deriv(sat_word(longint'(kd) * (e - e1)));
					held = clip((sum + 128) >>> 8, -lim, lim);
				end else begin
					sum = longint'(kp) * (e - e1) + longint'(ki) * e
						+ smooth_deriv(sat_word(longint'(kd) * (e - 2 * e1 + e2)));
					held = clip(held + ((sum + 128) >>> 8), -lim, lim);
				end
			end
			r.drive = held[15:0];
			r.status = STATUS_OK;
			drive_expected.push_back(r);
		endfunction

		task report_mismatch(string what);
			errors++;
			$display("MISMATCH at result %0d: %s", results_checked, what);
		endtask

		task check_drive(logic [DRIVE_W-1:0] drive, logic status);
			drive_result_t r;
			results_checked++;
			if (drive_expected.size() == 0) begin
				report_mismatch($sformatf("unexpected item drive %0d status %0b",
					$signed(drive), status));
			end else begin
				r = drive_expected.pop_front();
				if (drive !== r.drive) begin
					report_mismatch($sformatf("drive %0d, expected %0d",
						$signed(drive), $signed(r.drive)));
				end
				if (status !== r.status) begin
					report_mismatch($sformatf("status %0b, expected %0b", status, r.status));
				end
			end
		endtask
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic [31:0]           s_tdata = '0;
	logic                  s_tuser = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [DRIVE_W-1:0]    m_tdata;
	logic                  m_tuser;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	pid_scoreboard sb;
	int tx_style = 1;
	int rx_style = 1;
	int hold_requests = 0;
	int holds_done = 0;
	int rx_stall_left = 0;
	int idle_cycles = 0;
	int cfg_writes = 0;
	int settings = 0;

	pid_position_velocity u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// monitors and watchdog, all sampled at the rising edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				sb.take_sample(s_tuser, s_tdata[15:0], s_tdata[31:16]);
			end
			if (m_tvalid && m_tready) begin
				sb.check_drive(m_tdata, m_tuser);
			end
			if (cfg_valid && cfg_ready) begin
				sb.write_reg(cfg_reg_t'(cfg_index), cfg_data);
				cfg_writes++;
			end
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
				if (idle_cycles >= WATCHDOG_LIMIT) begin
					$display("Timeout: no handshake for %0d cycles", idle_cycles);
					$display("Verification failed");
					$finish;
				end
			end
		end
	end

	// result side: ready pattern per phase, plus one long hold-off on request
	always @(negedge clk) begin
		int r;
		if (hold_requests != holds_done) begin
			m_tready = 1'b0;
			repeat (HOLD_CYCLES) @(negedge clk);
			holds_done++;
		end else if (rx_stall_left > 0) begin
			m_tready = 1'b0;
			rx_stall_left--;
		end else if (rx_style == 0) begin
			m_tready = 1'b1;
		end else begin
			r = $urandom_range(0, 99);
			if (r < 70) begin
				m_tready = 1'b1;
			end else begin
				m_tready = 1'b0;
				rx_stall_left = (r < 97) ? $urandom_range(0, 3) : $urandom_range(20, 80);
			end
		end
	end

	// called at a falling edge; returns at the falling edge after acceptance, valid left high
	task automatic send_item(logic op, int tgt, int meas);
		int gap;
		int r;
		gap = 0;
		if (tx_style != 0) begin
			r = $urandom_range(0, 99);
			gap = (r < 60) ? 0 : ((r < 95) ? $urandom_range(1, 3) : $urandom_range(10, 60));
		end
		if (gap > 0) begin
			s_tvalid = 1'b0;
			s_tdata = $urandom();
			s_tuser = 1'($urandom_range(0, 1));
			repeat (gap) @(negedge clk);
		end
		s_tuser = op;
		s_tdata = {16'(meas), 16'(tgt)};
		s_tvalid = 1'b1;
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
	endtask

	task automatic wait_drained();
		s_tvalid = 1'b0;
		while (sb.drive_expected.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// bits above the register width are junk now and then; the block must ignore them
	task automatic write_cfg(cfg_reg_t idx, int val, int width);
		logic [31:0] mask;
		mask = (32'd1 << width) - 32'd1;
		cfg_index = idx;
		cfg_data = 32'(val) & mask;
		if ($urandom_range(0, 3) == 0) begin
			cfg_data = cfg_data | ($urandom() & ~mask);
		end
		cfg_valid = 1'b1;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
	endtask

	task automatic configure(int gp, int gi, int gd, int al, int dz, int il, int ol, int md);
		wait_drained();
		write_cfg(REG_GAIN_P, gp, 16);
		write_cfg(REG_GAIN_I, gi, 16);
		write_cfg(REG_GAIN_D, gd, 16);
		write_cfg(REG_FILTER_ALPHA, al, 16);
		write_cfg(REG_DEAD_ZONE, dz, 16);
		write_cfg(REG_INTEGRAL_LIMIT, il, 31);
		write_cfg(REG_OUTPUT_LIMIT, ol, 15);
		write_cfg(REG_LOOP_MODE, md, 2);
		cfg_valid = 1'b0;
		settings++;
	endtask

	function automatic int rand_gain();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0) begin
			return 0;
		end else if (r == 1) begin
			return $urandom_range(0, 1) ? 32767 : -32768;
		end else if (r < 6) begin
			return int'($urandom_range(0, 1024)) - 512;
		end
		return int'($urandom_range(0, 65535)) - 32768;
	endfunction

	initial begin
		int          phase, n_items, r, al, dz, il, ol, md;
		logic        op;
		logic [15:0] tgt, meas;
		sb = new();
		repeat (7) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// registers at reset: no mode selected
		send_item(OP_COMPUTE, 100, -5);
		send_item(OP_CLEAR, 0, 0);

		// positional, no filter, no dead zone
		configure(256, 64, -128, 0, 0, 20000, 32767, MODE_POS);
		send_item(OP_COMPUTE, 32767, -32768);
		send_item(OP_COMPUTE, -32768, 32767);
		send_item(OP_COMPUTE, 0, 0);
		send_item(OP_COMPUTE, 1000, 0);
		send_item(OP_COMPUTE, 1000, 0);
		send_item(OP_CLEAR, 1234, -99);
		send_item(OP_COMPUTE, 5, 5);

		// velocity with D filter and a dead zone
		configure(300, 100, 500, 40000, 50, 1000, 1000, MODE_VEL);
		send_item(OP_COMPUTE, 10, 0);
		send_item(OP_COMPUTE, 200, 0);
		send_item(OP_COMPUTE, -200, 0);
		send_item(OP_COMPUTE, 32767, -32768);
		send_item(OP_COMPUTE, -32768, 32767);
		send_item(OP_COMPUTE, 0, 0);
		send_item(OP_CLEAR, 0, 0);

		// extreme registers: zero integral gain, widest dead zone, zero output limit
		configure(-32768, 0, 32767, 65535, 65535, 32'h7FFF_FFFF, 0, MODE_POS);
		send_item(OP_COMPUTE, 32767, -32768);
		send_item(OP_COMPUTE, 0, 0);
		send_item(OP_COMPUTE, -32768, 32767);

		// mode code 3 behaves as unconfigured
		configure(32767, 32767, -32768, 1, 0, 0, 32767, 3);
		send_item(OP_COMPUTE, 77, 7);
		send_item(OP_CLEAR, 0, 0);

		phase = 0;
		while (sb.inputs_seen < ITEM_TARGET) begin
			r = $urandom_range(0, 3);
			al = (r < 2) ? 0 : ((r == 2) ? $urandom_range(1, 65535) : 65535);
			r = $urandom_range(0, 9);
			dz = (r < 6) ? $urandom_range(0, 20) : ((r < 8) ? $urandom_range(0, 2000)
				: ((r == 8) ? 65535 : $urandom_range(0, 65535)));
			r = $urandom_range(0, 9);
			il = (r < 3) ? $urandom_range(0, 5000) : ((r < 6) ? int'($urandom() >> 1)
				: ((r < 8) ? 32'h7FFF_FFFF : 0));
			r = $urandom_range(0, 9);
			ol = (r < 5) ? $urandom_range(0, 32767) : ((r < 7) ? 32767
				: ((r == 7) ? 0 : $urandom_range(1, 300)));
			r = $urandom_range(0, 19);
			md = (r < 9) ? MODE_POS : ((r < 18) ? MODE_VEL : ((r == 18) ? MODE_NONE : 3));
			configure(rand_gain(), rand_gain(), rand_gain(), al, dz, il, ol, md);

			tx_style = $urandom_range(0, 2);
			rx_style = $urandom_range(0, 2);
			if (phase == 2) begin
				// result side holds off while items keep coming
				tx_style = 0;
				hold_requests++;
			end
			n_items = $urandom_range(40, 140);
			repeat (n_items) begin
				op = ($urandom_range(0, 49) == 0) ? OP_CLEAR : OP_COMPUTE;
				r = $urandom_range(0, 3);
				if (r < 2) begin
					tgt = 16'($urandom());
					meas = tgt - 16'($urandom_range(0, 600)) + 16'd300;
				end else if (r == 2) begin
					tgt = 16'($urandom());
					meas = 16'($urandom());
				end else begin
					tgt = 16'($urandom_range(0, 600)) - 16'd300;
					meas = 16'($urandom_range(0, 60)) - 16'd30;
				end
				send_item(op, int'(tgt), int'(meas));
			end
			phase++;
		end

		wait_drained();
		repeat (TAIL_CYCLES) @(negedge clk);
		if (sb.drive_expected.size() != 0) begin
			sb.report_mismatch($sformatf("%0d expected items never came",
				sb.drive_expected.size()));
		end
		$display("Run covered %0d items (%0d clears) over %0d register settings, %0d writes",
			sb.inputs_seen, sb.clears_seen, settings, cfg_writes);
		$display("%0d result items checked, %0d mismatches", sb.results_checked, sb.errors);
		if (sb.errors == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule

FILE: pid_position_velocity.f
sv/pidpv_pkg.sv
sv/pid_position_velocity.sv
bench/tb_top.sv
